>>> src/hrbp_pkg.sv
// hrbp_pkg: types, codes and keyword constants for the http request byte parser
// no dependencies; imported by hrbp_rsp_if, the parser modules and the checker
`default_nettype none

package hrbp_pkg;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_BAD  = 2'd1,
      ST_DONE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ROLE_METHOD  = 3'd0,
      ROLE_BLANK   = 3'd1,
      ROLE_URL     = 3'd2,
      ROLE_VERSION = 3'd3,
      ROLE_HEADER  = 3'd4,
      ROLE_LINEEND = 3'd5,
      ROLE_BODY    = 3'd6
   } role_type;

   typedef enum logic [1:0] {
      MTH_NONE = 2'd0,
      MTH_GET  = 2'd1,
      MTH_POST = 2'd2
   } method_type;

   typedef enum logic [14:0] {
      PH_LEAD       = 15'h0001,
      PH_METHOD     = 15'h0002,
      PH_SEP        = 15'h0004,
      PH_BLANKS1    = 15'h0008,
      PH_URL        = 15'h0010,
      PH_BLANKS2    = 15'h0020,
      PH_VERSION    = 15'h0040,
      PH_VER_REST   = 15'h0080,
      PH_HDR        = 15'h0100,
      PH_HDR_WAIT   = 15'h0200,
      PH_HDR_DIGITS = 15'h0400,
      PH_HDR_END    = 15'h0800,
      PH_BODY       = 15'h1000,
      PH_DONE       = 15'h2000,
      PH_BAD        = 15'h4000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] kw_idx;
      method_type method;
      logic       cr_pending;
      logic       line_start;
      logic       header_match;
      status_type status;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      phase:        PH_LEAD,
      kw_idx:       4'd0,
      method:       MTH_NONE,
      cr_pending:   1'b0,
      line_start:   1'b1,
      header_match: 1'b0,
      status:       ST_MORE
   };

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_H     = 8'h48;

   localparam logic [23:0]  KW_GET  = "GET";
   localparam logic [31:0]  KW_POST = "POST";
   localparam logic [31:0]  KW_HTTP = "HTTP";
   localparam logic [119:0] KW_CLEN = "Content-Length:";

   // first character sits in the top byte
   function automatic logic [7:0] get_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = KW_GET[23:16];
         2'd1:    c = KW_GET[15:8];
         2'd2:    c = KW_GET[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] post_char(input logic [1:0] pos);
      return KW_POST[8 * (3 - int'(pos)) +: 8];
   endfunction

   function automatic logic [7:0] http_char(input logic [1:0] pos);
      return KW_HTTP[8 * (3 - int'(pos)) +: 8];
   endfunction

   function automatic logic [7:0] clen_char(input logic [3:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (pos != 4'd15) begin
         c = KW_CLEN[8 * (14 - int'(pos)) +: 8];
      end
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0c));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

endpackage

`default_nettype wire

>>> src/hrbp_req_if.sv
// hrbp_req_if: request byte channel, valid/ready with byte and restart flag
// depends on nothing
`default_nettype none

interface hrbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

>>> src/hrbp_rsp_if.sv
// hrbp_rsp_if: per-byte result channel, valid/ready with status, role and counters
// depends on hrbp_pkg
`default_nettype none

interface hrbp_rsp_if
   import hrbp_pkg::*;
#(
   parameter int LEN_W = 20,
   parameter int CNT_W = 13
);
   logic             valid;
   logic             ready;
   status_type       status;
   role_type         byte_role;
   method_type       method_seen;
   logic [LEN_W-1:0] body_length;
   logic [CNT_W-1:0] consumed_count;

   modport source (output valid, output status, output byte_role, output method_seen,
                   output body_length, output consumed_count, input ready);
   modport sink   (input valid, input status, input byte_role, input method_seen,
                   input body_length, input consumed_count, output ready);
endinterface

`default_nettype wire

>>> src/hrbp_step.sv
// hrbp_step: next-state and result logic for one request byte
// depends on hrbp_pkg; instantiated by http_request_byte_parser
`default_nettype none

module hrbp_step
   import hrbp_pkg::*;
#(
   parameter int BUF_BYTES = 4096,
   parameter int LEN_W     = 20,
   parameter int CNT_W     = 13
) (
   input  wire logic [7:0]       data_byte,
   input  wire logic             restart,
   input  wire ctrl_type         ctrl_cur,
   input  wire logic [LEN_W-1:0] len_cur,
   input  wire logic [LEN_W-1:0] body_cur,
   input  wire logic [CNT_W-1:0] cnt_cur,
   output ctrl_type              ctrl_nxt,
   output logic [LEN_W-1:0]      len_nxt,
   output logic [LEN_W-1:0]      body_nxt,
   output logic [CNT_W-1:0]      cnt_nxt,
   output role_type              role
);

   ctrl_type         cs;
   logic [LEN_W-1:0] len_s;
   logic [LEN_W-1:0] body_s;
   logic [CNT_W-1:0] cnt_s;
   logic             blank;
   logic             digit;
   logic             count_en;
   logic             hm;
   logic [3:0]       ki;
   logic [LEN_W+3:0] dec_sum;
   logic [LEN_W-1:0] body_inc;

   assign blank    = is_blank(data_byte);
   assign digit    = is_digit(data_byte);
   assign cs       = restart ? CTRL_RESET : ctrl_cur;
   assign len_s    = restart ? '0 : len_cur;
   assign body_s   = restart ? '0 : body_cur;
   assign cnt_s    = restart ? '0 : cnt_cur;
   assign body_inc = body_s + LEN_W'(1);
   assign dec_sum  = ({4'd0, len_s} << 3) + ({4'd0, len_s} << 1)
                   + (LEN_W + 4)'(data_byte[3:0]);

   always_comb begin
      ctrl_nxt = cs;
      len_nxt  = len_s;
      body_nxt = body_s;
      role     = ROLE_METHOD;
      count_en = 1'b0;
      hm       = cs.header_match;
      ki       = cs.kw_idx;

      if ((cs.phase == PH_BAD) || (cs.phase == PH_DONE)) begin
         role = ROLE_METHOD;
      end else if (cs.cr_pending) begin
         role = ROLE_LINEEND;
         if (data_byte == CHAR_LF) begin
            ctrl_nxt.cr_pending = 1'b0;
            ctrl_nxt.line_start = 1'b1;
            if (cs.phase == PH_HDR_END) begin
               if (len_s != '0) begin
                  ctrl_nxt.phase = PH_BODY;
               end else begin
                  ctrl_nxt.phase  = PH_DONE;
                  ctrl_nxt.status = ST_DONE;
               end
            end else begin
               ctrl_nxt.phase = PH_HDR;
            end
         end else begin
            ctrl_nxt.phase  = PH_BAD;
            ctrl_nxt.status = ST_BAD;
         end
      end else begin
         unique case (cs.phase) inside
            PH_LEAD: begin
               if (blank) begin
                  role = ROLE_BLANK;
               end else if (data_byte == CHAR_G) begin
                  ctrl_nxt.kw_idx = 4'd1;
                  ctrl_nxt.phase  = PH_METHOD;
               end else if (data_byte == CHAR_P) begin
                  ctrl_nxt.kw_idx = 4'd9;
                  ctrl_nxt.phase  = PH_METHOD;
               end else begin
                  role            = ROLE_BLANK;
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end
            end
            PH_METHOD: begin
               if (cs.kw_idx[3]) begin
                  if (!cs.kw_idx[2] && (data_byte == post_char(cs.kw_idx[1:0]))) begin
                     ctrl_nxt.kw_idx = cs.kw_idx + 4'd1;
                     if (cs.kw_idx[1:0] == 2'd3) begin
                        ctrl_nxt.method = MTH_POST;
                        ctrl_nxt.phase  = PH_SEP;
                     end
                  end else begin
                     ctrl_nxt.phase  = PH_BAD;
                     ctrl_nxt.status = ST_BAD;
                  end
               end else begin
                  if (!cs.kw_idx[2] && (cs.kw_idx[1:0] != 2'd3)
                      && (data_byte == get_char(cs.kw_idx[1:0]))) begin
                     ctrl_nxt.kw_idx = cs.kw_idx + 4'd1;
                     if (cs.kw_idx[1:0] == 2'd2) begin
                        ctrl_nxt.method = MTH_GET;
                        ctrl_nxt.phase  = PH_SEP;
                     end
                  end else begin
                     ctrl_nxt.phase  = PH_BAD;
                     ctrl_nxt.status = ST_BAD;
                  end
               end
            end
            PH_SEP: begin
               role = ROLE_BLANK;
               if (blank) begin
                  ctrl_nxt.phase = PH_BLANKS1;
               end else begin
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end
            end
            PH_BLANKS1: begin
               if (blank) begin
                  role = ROLE_BLANK;
               end else if (data_byte == CHAR_SLASH) begin
                  role           = ROLE_URL;
                  ctrl_nxt.phase = PH_URL;
               end else begin
                  role            = ROLE_BLANK;
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end
            end
            PH_URL: begin
               if (blank) begin
                  role           = ROLE_BLANK;
                  ctrl_nxt.phase = PH_BLANKS2;
               end else if (data_byte == CHAR_CR) begin
                  role            = ROLE_LINEEND;
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end else begin
                  role = ROLE_URL;
               end
            end
            PH_BLANKS2: begin
               if (blank) begin
                  role = ROLE_BLANK;
               end else if (data_byte == CHAR_H) begin
                  role            = ROLE_VERSION;
                  ctrl_nxt.kw_idx = 4'd1;
                  ctrl_nxt.phase  = PH_VERSION;
               end else begin
                  role            = ROLE_BLANK;
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end
            end
            PH_VERSION: begin
               role = ROLE_VERSION;
               if ((cs.kw_idx[3:2] == 2'd0) && (data_byte == http_char(cs.kw_idx[1:0]))) begin
                  ctrl_nxt.kw_idx = cs.kw_idx + 4'd1;
                  if (cs.kw_idx == 4'd3) begin
                     ctrl_nxt.phase = PH_VER_REST;
                  end
               end else begin
                  if (data_byte == CHAR_CR) begin
                     role = ROLE_LINEEND;
                  end
                  ctrl_nxt.phase  = PH_BAD;
                  ctrl_nxt.status = ST_BAD;
               end
            end
            PH_VER_REST: begin
               if (data_byte == CHAR_CR) begin
                  role                = ROLE_LINEEND;
                  ctrl_nxt.cr_pending = 1'b1;
                  ctrl_nxt.line_start = 1'b0;
                  ctrl_nxt.phase      = PH_HDR;
               end else begin
                  role = blank ? ROLE_BLANK : ROLE_VERSION;
               end
            end
            PH_HDR, PH_HDR_WAIT, PH_HDR_DIGITS: begin
               if (data_byte == CHAR_CR) begin
                  role                  = ROLE_LINEEND;
                  ctrl_nxt.cr_pending   = 1'b1;
                  ctrl_nxt.phase        = cs.line_start ? PH_HDR_END : PH_HDR;
                  ctrl_nxt.line_start   = 1'b0;
                  ctrl_nxt.header_match = 1'b0;
               end else begin
                  role                = ROLE_HEADER;
                  ctrl_nxt.line_start = 1'b0;
                  if (cs.phase == PH_HDR) begin
                     if (cs.line_start) begin
                        hm = 1'b1;
                        ki = 4'd0;
                     end
                     ctrl_nxt.header_match = hm;
                     ctrl_nxt.kw_idx       = ki;
                     if (hm) begin
                        if ((ki != 4'd15) && (data_byte == clen_char(ki))) begin
                           ctrl_nxt.kw_idx = ki + 4'd1;
                           if (ki == 4'd14) begin
                              ctrl_nxt.header_match = 1'b0;
                              len_nxt               = '0;
                              ctrl_nxt.phase        = PH_HDR_WAIT;
                           end
                        end else begin
                           ctrl_nxt.header_match = 1'b0;
                        end
                     end
                  end else if (cs.phase == PH_HDR_WAIT) begin
                     if (digit) begin
                        len_nxt        = LEN_W'(data_byte[3:0]);
                        ctrl_nxt.phase = PH_HDR_DIGITS;
                     end
                  end else begin
                     if (digit) begin
                        len_nxt = (dec_sum[LEN_W+3:LEN_W] != 4'd0) ? '1 : dec_sum[LEN_W-1:0];
                     end else begin
                        ctrl_nxt.phase = PH_HDR;
                     end
                  end
               end
            end
            PH_BODY: begin
               role     = ROLE_BODY;
               body_nxt = body_inc;
               if (body_inc >= len_s) begin
                  ctrl_nxt.phase  = PH_DONE;
                  ctrl_nxt.status = ST_DONE;
               end
            end
            default: begin
               ctrl_nxt.phase  = PH_BAD;
               ctrl_nxt.status = ST_BAD;
            end
         endcase
         count_en = (ctrl_nxt.phase != PH_BAD);
      end
   end

   assign cnt_nxt = (count_en && (cnt_s < CNT_W'(BUF_BYTES))) ? cnt_s + CNT_W'(1) : cnt_s;

endmodule

`default_nettype wire

>>> src/http_request_byte_parser.sv
// http_request_byte_parser: top level, input register, parser state and result register
// depends on hrbp_pkg, hrbp_req_if, hrbp_rsp_if and hrbp_step
// path: an accepted request byte goes through the input register, then the result register
// throughput: one byte per cycle while the result beat is not held; the hrbp_step update is combinational
// stalls: a held result beat still lets the input register take one more byte
// reset: synchronous, clears all parser state and both valid flags; restart clears per byte
`default_nettype none

module http_request_byte_parser
   import hrbp_pkg::*;
#(
   parameter int BUF_BYTES = 4096,
   parameter int LEN_BITS  = 20
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hrbp_req_if.sink    req_bus,
   hrbp_rsp_if.source  rsp_bus
);

   localparam int CNT_W = $clog2(BUF_BYTES + 1);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_restart_ff;
   logic                take_in;
   logic                advance;

   ctrl_type            ctrl_ff;
   ctrl_type            ctrl_in;
   logic [LEN_BITS-1:0] len_ff;
   logic [LEN_BITS-1:0] len_in;
   logic [LEN_BITS-1:0] body_ff;
   logic [LEN_BITS-1:0] body_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   role_type            role_in;

   logic                out_valid_ff;
   logic                out_valid_in;
   status_type          out_status_ff;
   role_type            out_role_ff;
   method_type          out_method_ff;
   logic [LEN_BITS-1:0] out_len_ff;
   logic [CNT_W-1:0]    out_cnt_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign take_in      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   hrbp_step #(
      .BUF_BYTES(BUF_BYTES),
      .LEN_W    (LEN_BITS),
      .CNT_W    (CNT_W)
   ) u_step (
      .data_byte(in_byte_ff),
      .restart  (in_restart_ff),
      .ctrl_cur (ctrl_ff),
      .len_cur  (len_ff),
      .body_cur (body_ff),
      .cnt_cur  (cnt_ff),
      .ctrl_nxt (ctrl_in),
      .len_nxt  (len_in),
      .body_nxt (body_in),
      .cnt_nxt  (cnt_in),
      .role     (role_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= CTRL_RESET;
         len_ff       <= '0;
         body_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctrl_ff <= ctrl_in;
            len_ff  <= len_in;
            body_ff <= body_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff    <= req_bus.data_byte;
         in_restart_ff <= req_bus.restart;
      end
      if (advance) begin
         out_status_ff <= ctrl_in.status;
         out_role_ff   <= role_in;
         out_method_ff <= ctrl_in.method;
         out_len_ff    <= len_in;
         out_cnt_ff    <= cnt_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_status_ff;
   assign rsp_bus.byte_role      = out_role_ff;
   assign rsp_bus.method_seen    = out_method_ff;
   assign rsp_bus.body_length    = out_len_ff;
   assign rsp_bus.consumed_count = out_cnt_ff;

endmodule

`default_nettype wire

>>> src/hrbp_checker.sv
// hrbp_checker: port-level assertions for http_request_byte_parser
// depends on hrbp_pkg; attached to the top level by the bind below
`default_nettype none

module hrbp_checker
   import hrbp_pkg::*;
#(
   parameter int BUF_BYTES = 4096,
   parameter int LEN_W     = 20,
   parameter int CNT_W     = 13
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire status_type       rsp_status,
   input wire role_type         rsp_byte_role,
   input wire method_type       rsp_method_seen,
   input wire logic [LEN_W-1:0] rsp_body_length,
   input wire logic [CNT_W-1:0] rsp_consumed_count
);

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_byte_role) && $stable(rsp_consumed_count))
      else $error("stalled result beat changed");

   a_done_method : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DONE) |-> (rsp_method_seen != MTH_NONE))
      else $error("request complete without a method");

   a_body_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_BODY)
         |-> (rsp_body_length != '0) && (rsp_status != ST_BAD))
      else $error("body beat without a content length");

   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_consumed_count <= CNT_W'(BUF_BYTES)))
      else $error("consumed count above buffer size");

endmodule

bind http_request_byte_parser hrbp_checker #(
   .BUF_BYTES(BUF_BYTES),
   .LEN_W    (LEN_BITS),
   .CNT_W    (CNT_W)
) u_hrbp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_byte_role     (rsp_bus.byte_role),
   .rsp_method_seen   (rsp_bus.method_seen),
   .rsp_body_length   (rsp_bus.body_length),
   .rsp_consumed_count(rsp_bus.consumed_count)
);

`default_nettype wire
